// ===== design/fcbm_pkg.sv =====
// Shared types and constants for the block mapper with its chain link table.
// It has no dependencies. The controller, the datapath and the top level use it.
package fcbm_pkg;

  // Field widths of the input and result items.
  localparam int FIRST_W    = 10;
  localparam int POS_W      = 19;
  localparam int REM_W      = 20;
  localparam int PHYS_W     = 10;
  localparam int OFF_W      = 9;
  localparam int CHUNK_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int LBLK_W     = POS_W - OFF_W;

  // The block size matches the offset field, so the position split is a plain bit split.
  localparam int BLOCK_BYTES = 1 << OFF_W;

  // Link table entries.
  localparam int               LINK_W   = 16;
  localparam logic [LINK_W-1:0] LINK_END = '1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration registers.
  localparam int DSTART_W = 10;
  localparam int TOTAL_W  = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b1;
  localparam logic [DSTART_W-1:0]  DSTART_RST = 10'd1;
  localparam logic [TOTAL_W-1:0]   TOTAL_RST  = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BROKEN = 2'd2
  } status_t;

  // Where the reported block comes from.
  typedef enum logic [1:0] {
    PHYS_ZERO = 2'd0,
    PHYS_CUR  = 2'd1,
    PHYS_NEW  = 2'd2
  } phys_src_t;

  typedef struct packed {
    logic [FIRST_W-1:0] file_first_block;
    logic [POS_W-1:0]   byte_position;
    logic [REM_W-1:0]   remaining_len;
  } in_item_t;

  typedef struct packed {
    logic [PHYS_W-1:0]  phys_block;
    logic [OFF_W-1:0]   block_offset;
    logic [CHUNK_W-1:0] chunk_len;
    logic               did_allocate;
    status_t            status;
    logic [COUNT_W-1:0] blocks_allocated;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      clr_wr;
    logic      rd_walk;
    logic      walk_adv;
    logic      scan_start;
    logic      scan_step;
    logic      alloc_end;
    logic      alloc_link;
    logic      finish;
    phys_src_t phys_src;
    status_t   res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic rem_zero;
    logic lblk_zero;
    logic first_zero;
    logic cur_bad;
    logic cnt_over;
    logic cnt_hit;
    logic link_end;
    logic next_last;
    logic found;
    logic scan_more;
  } sts_t;

endpackage

// ===== design/fcbm_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// It has no dependencies.
module fcbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fcbm_ctrl.sv =====
// Sequencing state machine: clearing pass, chain walk, free search and allocation.
// It depends on fcbm_pkg for the command and status structs.
module fcbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  fcbm_pkg::sts_t sts,
  output fcbm_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR      = 8'b0000_0001,
    S_IDLE       = 8'b0000_0010,
    S_DECIDE     = 8'b0000_0100,
    S_WALK       = 8'b0000_1000,
    S_WALK_WAIT  = 8'b0001_0000,
    S_SCAN       = 8'b0010_0000,
    S_ALLOC_END  = 8'b0100_0000,
    S_ALLOC_LINK = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.phys_src   = fcbm_pkg::PHYS_ZERO;
    cmd.res_status = fcbm_pkg::ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.rem_zero) begin
          cmd.finish = 1'b1;
        end else if (sts.lblk_zero) begin
          if (sts.first_zero) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.finish   = 1'b1;
            cmd.phys_src = fcbm_pkg::PHYS_CUR;
          end
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.cnt_over || sts.cur_bad) begin
          cmd.finish     = 1'b1;
          cmd.res_status = fcbm_pkg::ST_BROKEN;
        end else if (sts.cnt_hit) begin
          cmd.finish   = 1'b1;
          cmd.phys_src = fcbm_pkg::PHYS_CUR;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        if (sts.link_end) begin
          if (sts.next_last) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.finish     = 1'b1;
            cmd.res_status = fcbm_pkg::ST_BROKEN;
          end
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_WALK;
        end
      end
      S_SCAN: begin
        if (sts.found) begin
          state_nxt = S_ALLOC_END;
        end else if (!sts.scan_more) begin
          cmd.finish     = 1'b1;
          cmd.res_status = fcbm_pkg::ST_FULL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ALLOC_END: begin
        cmd.alloc_end = 1'b1;
        if (sts.lblk_zero) begin
          cmd.finish   = 1'b1;
          cmd.phys_src = fcbm_pkg::PHYS_NEW;
        end else begin
          state_nxt = S_ALLOC_LINK;
        end
      end
      S_ALLOC_LINK: begin
        cmd.alloc_link = 1'b1;
        cmd.finish     = 1'b1;
        cmd.phys_src   = fcbm_pkg::PHYS_NEW;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.finish) begin
      state_nxt = S_IDLE;
    end
    out_valid_nxt = cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/fcbm_dp.sv =====
// Datapath: configuration registers, request registers, walk and search counters,
// the link table RAM and the result register. It depends on fcbm_pkg and fcbm_ram.
module fcbm_dp #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fcbm_pkg::in_item_t                in_item,
  input  logic                              cfg_we,
  input  logic [fcbm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [fcbm_pkg::CFG_W-1:0]        cfg_wdata,
  input  fcbm_pkg::cmd_t                    cmd,
  output fcbm_pkg::sts_t                    sts,
  output fcbm_pkg::out_item_t               out_item
);

  localparam int AW    = $clog2(NUM_BLOCKS);
  localparam int SW    = (AW + 1 > fcbm_pkg::TOTAL_W) ? AW + 1 : fcbm_pkg::TOTAL_W;
  localparam int NCW   = $clog2(NUM_BLOCKS + 1);
  localparam int CNTW  = (NCW > fcbm_pkg::LBLK_W) ? NCW : fcbm_pkg::LBLK_W;
  localparam int LW    = fcbm_pkg::LINK_W;

  // Configuration.
  logic [fcbm_pkg::DSTART_W-1:0] dstart_r;
  logic [fcbm_pkg::TOTAL_W-1:0]  total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstart_r <= fcbm_pkg::DSTART_RST;
      total_r  <= fcbm_pkg::TOTAL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        fcbm_pkg::CFG_ALLOC_BASE:   dstart_r <= cfg_wdata[fcbm_pkg::DSTART_W-1:0];
        fcbm_pkg::CFG_TOTAL_BLOCKS: total_r  <= cfg_wdata[fcbm_pkg::TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request registers and walk state.
  logic [fcbm_pkg::FIRST_W-1:0] first_r;
  logic [fcbm_pkg::LBLK_W-1:0]  lblk_r;
  logic [fcbm_pkg::OFF_W-1:0]   off_r;
  logic [fcbm_pkg::REM_W-1:0]   rem_r;
  logic [LW-1:0]                cur_r;
  logic [CNTW-1:0]              cnt_r;
  logic [LW-1:0]                rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= in_item.file_first_block;
      lblk_r  <= in_item.byte_position[fcbm_pkg::POS_W-1:fcbm_pkg::OFF_W];
      off_r   <= in_item.byte_position[fcbm_pkg::OFF_W-1:0];
      rem_r   <= in_item.remaining_len;
      cur_r   <= LW'(in_item.file_first_block);
      cnt_r   <= '0;
    end else if (cmd.walk_adv) begin
      cur_r <= rdata;
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  // Free search: one read issued per cycle, the result checked in the cycle after.
  logic [SW-1:0] scan_addr_r;
  logic          pend_v_r;
  logic [AW-1:0] pend_addr_r;
  logic [SW-1:0] scan_lo, scan_hi;

  assign scan_lo = (dstart_r == '0) ? SW'(1) : SW'(dstart_r);
  assign scan_hi = (SW'(total_r) < SW'(NUM_BLOCKS)) ? SW'(total_r) : SW'(NUM_BLOCKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.scan_start) begin
      pend_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      pend_v_r <= sts.scan_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr_r <= scan_lo;
    end else if (cmd.scan_step) begin
      pend_addr_r <= scan_addr_r[AW-1:0];
      if (sts.scan_more) begin
        scan_addr_r <= scan_addr_r + SW'(1);
      end
    end
  end

  // Clearing pass address.
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Link table.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0] ram_wdata;

  always_comb begin
    ram_we    = cmd.clr_wr | cmd.alloc_end | cmd.alloc_link;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    if (cmd.alloc_end) begin
      ram_waddr = pend_addr_r;
      ram_wdata = fcbm_pkg::LINK_END;
    end else if (cmd.alloc_link) begin
      ram_waddr = cur_r[AW-1:0];
      ram_wdata = LW'(pend_addr_r);
    end
    ram_raddr = cmd.rd_walk ? cur_r[AW-1:0] : scan_addr_r[AW-1:0];
  end

  fcbm_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Status towards the controller.
  always_comb begin
    sts.clr_last   = (clr_addr_r == AW'(NUM_BLOCKS - 1));
    sts.rem_zero   = (rem_r == '0);
    sts.lblk_zero  = (lblk_r == '0);
    sts.first_zero = (first_r == '0);
    sts.cur_bad    = (cur_r == '0) || ({1'b0, cur_r} >= (LW + 1)'(NUM_BLOCKS));
    sts.cnt_over   = (cnt_r >= CNTW'(NUM_BLOCKS));
    sts.cnt_hit    = (cnt_r == CNTW'(lblk_r));
    sts.link_end   = (rdata == fcbm_pkg::LINK_END);
    sts.next_last  = (({1'b0, cnt_r} + (CNTW + 1)'(1)) == (CNTW + 1)'(lblk_r));
    sts.found      = pend_v_r && (rdata == '0);
    sts.scan_more  = (scan_addr_r < scan_hi);
  end

  // Allocation counter, saturating.
  logic [fcbm_pkg::COUNT_W-1:0] count_r, count_nxt;

  assign count_nxt = (cmd.alloc_end && count_r != fcbm_pkg::COUNT_MAX) ?
                     count_r + fcbm_pkg::COUNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register.
  logic [LW-1:0]                  phys_full;
  logic [fcbm_pkg::CHUNK_W-1:0]   space, chunk;
  fcbm_pkg::out_item_t            res_r;

  always_comb begin
    case (cmd.phys_src)
      fcbm_pkg::PHYS_CUR: phys_full = cur_r;
      fcbm_pkg::PHYS_NEW: phys_full = LW'(pend_addr_r);
      default:            phys_full = '0;
    endcase
    space = fcbm_pkg::CHUNK_W'(fcbm_pkg::BLOCK_BYTES) - fcbm_pkg::CHUNK_W'(off_r);
    chunk = (rem_r < fcbm_pkg::REM_W'(space)) ? fcbm_pkg::CHUNK_W'(rem_r) : space;
    if (cmd.res_status != fcbm_pkg::ST_OK) begin
      chunk = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r.phys_block       <= fcbm_pkg::PHYS_W'(phys_full);
      res_r.block_offset     <= off_r;
      res_r.chunk_len        <= chunk;
      res_r.did_allocate     <= (cmd.phys_src == fcbm_pkg::PHYS_NEW);
      res_r.status           <= cmd.res_status;
      res_r.blocks_allocated <= count_nxt;
    end
  end

  assign out_item = res_r;

endmodule

// ===== design/fat_chain_block_mapper.sv =====
// Top level of the block mapper: maps a byte position in a file onto a block of a
// chained link table, allocating a first block or a block at a chain's end when needed.
// It depends on fcbm_pkg, fcbm_ctrl, fcbm_dp and fcbm_ram.
//
//   Channel   Ports                                   Transfer
//   -------   -------------------------------------   --------------------------------
//   request   start, busy, in_item                    item taken when start && !busy
//   result    out_valid, out_item                     one-cycle strobe, never held off
//   config    cfg_we, cfg_idx, cfg_wdata              written when cfg_we is high
//
// After reset the table is swept to zero one entry a cycle, keeping busy high until done.
// The decide state ends an empty write or a given first block; a walk takes each chain
// block through a read state and a wait state and ends in the read state at the block
// found. A free search reads the entries in turn, then a state marks the new block and,
// for a chain extension, another links it. The result strobe is high in the first cycle
// with busy low, when the next item may already be taken; nothing stalls it.
module fat_chain_block_mapper #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  fcbm_pkg::in_item_t             in_item,
  output logic                           out_valid,
  output fcbm_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [fcbm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fcbm_pkg::CFG_W-1:0]     cfg_wdata
);

  // The controller only sequences; all state of the table and the item is in the datapath.
  fcbm_pkg::cmd_t cmd;
  fcbm_pkg::sts_t sts;

  fcbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the link table, the allocation count and the result register.
  fcbm_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for fat_chain_block_mapper: a directed table of requests, then random file
// writes, with every result checked against a typed expectation or a prediction from a
// behavioural copy of the link table. Depends on fcbm_pkg and the RTL of the block mapper.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_BLOCKS      = 1024;
  localparam int FILE_SLOTS      = 8;
  localparam int MAX_FILE_BLOCKS = 40;
  localparam int PHASE_ITEMS     = 190;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 64;
  localparam logic [fcbm_pkg::REM_W-1:0] REM_MAX = 20'd524288;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

  // One line of the directed table: either a request item or a register write.
  typedef struct packed {
    row_kind_t                      kind;
    logic [fcbm_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [fcbm_pkg::CFG_W-1:0]     reg_val;
    fcbm_pkg::in_item_t             req;
    logic                           known;
    fcbm_pkg::out_item_t            want;
  } script_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  fcbm_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  fcbm_pkg::out_item_t out_item;
  logic                           cfg_we    = 1'b0;
  logic [fcbm_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [fcbm_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // Behavioural copy of the block's state and configuration.
  logic [fcbm_pkg::LINK_W-1:0]   link_map [NUM_BLOCKS];
  logic [fcbm_pkg::COUNT_W-1:0]  granted_count;
  logic [fcbm_pkg::DSTART_W-1:0] alloc_floor;
  logic [fcbm_pkg::TOTAL_W-1:0]  alloc_ceiling;

  // First block of each file that the random part writes to sequentially; 0 means
  // the file has not been given a block yet.
  logic [fcbm_pkg::FIRST_W-1:0] file_head [FILE_SLOTS];

  fcbm_pkg::out_item_t expected_mappings [$];
  script_row_t         script [$];
  fcbm_pkg::out_item_t oldest;
  int unsigned requests_issued = 0;
  int unsigned results_seen    = 0;
  int unsigned error_count     = 0;
  int unsigned quiet_cycles    = 0;

  fat_chain_block_mapper #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Takes the lowest free block of the allowed window, marks it as the end of a chain
  // and counts it. Block 0 stands for "none", so the window never starts below 1.
  function automatic bit claim_free_block(output int unsigned blk);
    int unsigned lo;
    int unsigned hi;
    lo  = (alloc_floor == 0) ? 1 : alloc_floor;
    hi  = (alloc_ceiling < NUM_BLOCKS) ? alloc_ceiling : NUM_BLOCKS;
    blk = 0;
    for (int unsigned i = lo; i < hi; i++) begin
      if (link_map[i] == '0) begin
        link_map[i] = fcbm_pkg::LINK_END;
        if (granted_count != fcbm_pkg::COUNT_MAX) granted_count++;
        blk = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the answer to one request and applies its allocation, if any.
  function automatic fcbm_pkg::out_item_t map_request(input fcbm_pkg::in_item_t req);
    fcbm_pkg::out_item_t         res;
    logic [fcbm_pkg::LBLK_W-1:0] lblk;
    logic [fcbm_pkg::OFF_W-1:0]  off;
    int unsigned                 cur;
    int unsigned                 cnt;
    int unsigned                 nb;
    int unsigned                 space;
    res   = '0;
    lblk  = req.byte_position[fcbm_pkg::POS_W-1:fcbm_pkg::OFF_W];
    off   = req.byte_position[fcbm_pkg::OFF_W-1:0];
    res.block_offset = off;
    res.status       = fcbm_pkg::ST_OK;
    if (req.remaining_len == 0) begin
      // Nothing to write: no lookup and no allocation.
    end else if (lblk == 0) begin
      if (req.file_first_block == 0) begin
        if (claim_free_block(nb)) begin
          res.phys_block   = fcbm_pkg::PHYS_W'(nb);
          res.did_allocate = 1'b1;
        end else begin
          res.status = fcbm_pkg::ST_FULL;
        end
      end else begin
        res.phys_block = req.file_first_block;
      end
    end else begin
      res.status = fcbm_pkg::ST_BROKEN;
      cur = req.file_first_block;
      cnt = 0;
      for (int unsigned steps = 0; steps < NUM_BLOCKS; steps++) begin
        if (cur == 0 || cur >= NUM_BLOCKS) break;
        if (cnt == lblk) begin
          res.phys_block = fcbm_pkg::PHYS_W'(cur);
          res.status     = fcbm_pkg::ST_OK;
          break;
        end
        if (link_map[cur] == fcbm_pkg::LINK_END) begin
          // Only a chain that ends just before the wanted block is extended.
          if (cnt + 1 == lblk) begin
            if (claim_free_block(nb)) begin
              link_map[cur]    = fcbm_pkg::LINK_W'(nb);
              res.phys_block   = fcbm_pkg::PHYS_W'(nb);
              res.did_allocate = 1'b1;
              res.status       = fcbm_pkg::ST_OK;
            end else begin
              res.status = fcbm_pkg::ST_FULL;
            end
          end
          break;
        end
        cur = link_map[cur];
        cnt++;
      end
    end
    if (res.status != fcbm_pkg::ST_OK) begin
      res.phys_block = '0;
    end else if (req.remaining_len != 0) begin
      space = fcbm_pkg::BLOCK_BYTES - off;
      res.chunk_len = (req.remaining_len < space) ? fcbm_pkg::CHUNK_W'(req.remaining_len)
                                                  : fcbm_pkg::CHUNK_W'(space);
    end
    res.blocks_allocated = granted_count;
    return res;
  endfunction

  // Number of blocks in the chain that starts at head, as the copy of the table holds it.
  function automatic int unsigned chain_length(input logic [fcbm_pkg::FIRST_W-1:0] head);
    int unsigned n;
    int unsigned cur;
    n   = 0;
    cur = head;
    while (cur != 0 && cur < NUM_BLOCKS && n < NUM_BLOCKS) begin
      n++;
      if (link_map[cur] == fcbm_pkg::LINK_END) break;
      cur = link_map[cur];
    end
    return n;
  endfunction

  function automatic fcbm_pkg::out_item_t result_of(input int unsigned phys,
                                                    input int unsigned off,
                                                    input int unsigned chunk,
                                                    input int unsigned did,
                                                    input fcbm_pkg::status_t st,
                                                    input int unsigned count);
    fcbm_pkg::out_item_t res;
    res.phys_block       = fcbm_pkg::PHYS_W'(phys);
    res.block_offset     = fcbm_pkg::OFF_W'(off);
    res.chunk_len        = fcbm_pkg::CHUNK_W'(chunk);
    res.did_allocate     = did[0];
    res.status           = st;
    res.blocks_allocated = fcbm_pkg::COUNT_W'(count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Every mismatch is counted and printed on one line.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic compare_mapping(input fcbm_pkg::out_item_t got,
                                 input fcbm_pkg::out_item_t want,
                                 input int unsigned idx);
    if (got.phys_block !== want.phys_block)
      report_mismatch($sformatf("result %0d phys_block %0d, expected %0d",
                                idx, got.phys_block, want.phys_block));
    if (got.block_offset !== want.block_offset)
      report_mismatch($sformatf("result %0d block_offset %0d, expected %0d",
                                idx, got.block_offset, want.block_offset));
    if (got.chunk_len !== want.chunk_len)
      report_mismatch($sformatf("result %0d chunk_len %0d, expected %0d",
                                idx, got.chunk_len, want.chunk_len));
    if (got.did_allocate !== want.did_allocate)
      report_mismatch($sformatf("result %0d did_allocate %0d, expected %0d",
                                idx, got.did_allocate, want.did_allocate));
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                idx, got.status, want.status));
    if (got.blocks_allocated !== want.blocks_allocated)
      report_mismatch($sformatf("result %0d blocks_allocated %0d, expected %0d",
                                idx, got.blocks_allocated, want.blocks_allocated));
  endtask

  // Results are sampled at the rising edge that ends their strobe cycle. The count of
  // results seen is updated with a nonblocking assignment, so the stimulus process
  // reads a value that does not depend on the order of processes at that edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_mappings.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        oldest = expected_mappings.pop_front();
        compare_mapping(out_item, oldest, results_seen);
        results_seen <= results_seen + 1;
      end
    end
  end

  // The watchdog ends the run once nothing has moved on either channel for too long.
  // The limit covers the longest correct item, which walks a whole table and scans it once
  // more, and also the clearing pass after reset.
  always @(posedge clk) begin
    if (rst_n && ((start && busy === 1'b0) || out_valid === 1'b1)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Geometric idle gap: each further cycle is idle with the given chance.
  function automatic int unsigned draw_gap(input int unsigned idle_pct);
    int unsigned g;
    g = 0;
    while (g < 24 && $urandom_range(0, 99) < idle_pct) g++;
    return g;
  endfunction

  // Presents one item, holds it until the block takes it, records the expectation and
  // then leaves start low for the given gap. The typed expectation of a directed row
  // takes the place of the predicted one, but the predictor still runs so that its
  // copy of the table follows the block.
  task automatic send_request(input fcbm_pkg::in_item_t req, input int unsigned gap,
                              input bit known, input fcbm_pkg::out_item_t want,
                              output fcbm_pkg::out_item_t predicted);
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = map_request(req);
    expected_mappings.push_back(known ? want : predicted);
    requests_issued++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Registers are only written with no request outstanding and the block idle. Every
  // item gives exactly one result, so once all results are in the block has stopped.
  task automatic write_register(input logic [fcbm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [fcbm_pkg::CFG_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (requests_issued != results_seen || busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fcbm_pkg::CFG_ALLOC_BASE) alloc_floor = val[fcbm_pkg::DSTART_W-1:0];
    else alloc_ceiling = val[fcbm_pkg::TOTAL_W-1:0];
  endtask

  task automatic add_request(input int unsigned first, input int unsigned pos,
                             input int unsigned rem, input bit known,
                             input fcbm_pkg::out_item_t want);
    script_row_t row;
    row = '0;
    row.kind                 = ROW_REQUEST;
    row.req.file_first_block = fcbm_pkg::FIRST_W'(first);
    row.req.byte_position    = fcbm_pkg::POS_W'(pos);
    row.req.remaining_len    = fcbm_pkg::REM_W'(rem);
    row.known                = known;
    row.want                 = want;
    script.push_back(row);
  endtask

  task automatic add_write(input logic [fcbm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    script_row_t row;
    row = '0;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = fcbm_pkg::CFG_W'(val);
    script.push_back(row);
  endtask

  // Random part. Most items are sequential writes to a handful of files: a file gets
  // its first block with a request at position zero, and later requests land inside
  // the chain or one block past its end, which makes the block extend the chain. The
  // rest are empty writes, walks from arbitrary blocks, chains too short for the
  // position and positions past block zero with no first block.
  task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct);
    fcbm_pkg::in_item_t  req;
    fcbm_pkg::out_item_t pred;
    int unsigned pick;
    int unsigned slot;
    int unsigned first;
    int unsigned lblk;
    int unsigned off;
    int unsigned rem;
    int unsigned len;
    bit          creating;
    for (int unsigned n = 0; n < count; n++) begin
      creating = 1'b0;
      slot     = $urandom_range(0, FILE_SLOTS - 1);
      case ($urandom_range(0, 4))
        0:       off = 0;
        1:       off = fcbm_pkg::BLOCK_BYTES - 1;
        default: off = $urandom_range(0, fcbm_pkg::BLOCK_BYTES - 1);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    rem = $urandom_range(1, 16);
        2, 3, 4: rem = $urandom_range(1, 700);
        5:       rem = REM_MAX;
        default: rem = $urandom_range(1, REM_MAX);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Long files are dropped and started afresh to keep the walks short.
        if (file_head[slot] != 0 && chain_length(file_head[slot]) >= MAX_FILE_BLOCKS)
          file_head[slot] = '0;
        first = file_head[slot];
        if (first == 0) begin
          lblk     = 0;
          creating = 1'b1;
        end else begin
          len  = chain_length(file_head[slot]);
          lblk = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : len;
        end
      end else if (pick < 75) begin
        rem   = 0;
        first = $urandom_range(0, NUM_BLOCKS - 1);
        lblk  = $urandom_range(0, NUM_BLOCKS - 1);
      end else if (pick < 85) begin
        first = $urandom_range(0, NUM_BLOCKS - 1);
        lblk  = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                     : $urandom_range(0, NUM_BLOCKS - 1);
      end else if (pick < 93) begin
        first = file_head[slot];
        if (first == 0) lblk = $urandom_range(1, NUM_BLOCKS - 1);
        else lblk = chain_length(file_head[slot]) + 1 + $urandom_range(0, 4);
      end else begin
        first = 0;
        lblk  = $urandom_range(1, NUM_BLOCKS - 1);
      end
      if (lblk > NUM_BLOCKS - 1) lblk = NUM_BLOCKS - 1;
      req.file_first_block = fcbm_pkg::FIRST_W'(first);
      req.byte_position    = {fcbm_pkg::LBLK_W'(lblk), fcbm_pkg::OFF_W'(off)};
      req.remaining_len    = fcbm_pkg::REM_W'(rem);
      send_request(req, draw_gap(idle_pct), 1'b0, '0, pred);
      if (creating && pred.did_allocate) file_head[slot] = pred.phys_block;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    fcbm_pkg::out_item_t pred;
    script_row_t         row;
    int unsigned p_floor;
    int unsigned p_ceiling;
    int unsigned p_idle;

    foreach (link_map[i]) link_map[i] = '0;
    foreach (file_head[i]) file_head[i] = '0;
    granted_count = '0;
    alloc_floor   = fcbm_pkg::DSTART_RST;
    alloc_ceiling = fcbm_pkg::TOTAL_RST;

    // Directed table. Expectations are typed in where they follow directly from an
    // empty table after reset; the other rows are left to the predictor.
    // An empty write reports the offset only, even at the largest position.
    add_request(1023, 524287, 0, 1'b1, result_of(0, 511, 0, 0, fcbm_pkg::ST_OK, 0));
    // A new file takes the first free block from the allocation base up.
    add_request(0, 0, 1, 1'b1, result_of(1, 0, 1, 1, fcbm_pkg::ST_OK, 1));
    // The chain ends just before the wanted block, so it is extended.
    add_request(1, 512, REM_MAX, 1'b1, result_of(2, 0, 512, 1, fcbm_pkg::ST_OK, 2));
    // Last byte of a block: only one byte of space is left.
    add_request(1, 1023, REM_MAX, 1'b1, result_of(2, 511, 1, 0, fcbm_pkg::ST_OK, 2));
    // Chain too short: it ends two blocks before the wanted one.
    add_request(1, 1536, 40, 1'b1, result_of(0, 0, 0, 0, fcbm_pkg::ST_BROKEN, 2));
    // Past block zero with no first block.
    add_request(0, 512, 5, 1'b1, result_of(0, 0, 0, 0, fcbm_pkg::ST_BROKEN, 2));
    // Walk from a free block meets a zero link.
    add_request(5, 512, 10, 1'b1, result_of(0, 0, 0, 0, fcbm_pkg::ST_BROKEN, 2));
    // A given first block at logical block zero is returned without a table lookup.
    add_request(1023, 0, 7, 1'b1, result_of(1023, 0, 7, 0, fcbm_pkg::ST_OK, 2));
    add_request(1023, 524287, 100, 1'b1,
                result_of(0, 511, 0, 0, fcbm_pkg::ST_BROKEN, 2));
    add_request(1, 1024, 600, 1'b0, '0);
    // Walk that starts in the middle of a chain.
    add_request(2, 529, 1000, 1'b0, '0);
    // With the allocation base at zero the search still starts at block 1.
    add_write(fcbm_pkg::CFG_ALLOC_BASE, 0);
    add_request(0, 0, 512, 1'b0, '0);
    // An empty search window leaves the disk full.
    add_write(fcbm_pkg::CFG_TOTAL_BLOCKS, 1);
    add_request(0, 200, 50, 1'b1, result_of(0, 200, 0, 0, fcbm_pkg::ST_FULL, 4));
    add_request(1, 1536, 300, 1'b0, '0);
    // A window of the very last block only.
    add_write(fcbm_pkg::CFG_ALLOC_BASE, 1023);
    add_write(fcbm_pkg::CFG_TOTAL_BLOCKS, 1024);
    add_request(0, 300, REM_MAX, 1'b0, '0);
    add_request(0, 0, 1, 1'b1, result_of(0, 0, 0, 0, fcbm_pkg::ST_FULL, 5));
    add_request(1023, 512, 3, 1'b0, '0);
    add_write(fcbm_pkg::CFG_ALLOC_BASE, 1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The first item is held until the clearing pass after reset is over.
    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_WRITE) write_register(row.reg_idx, row.reg_val);
      else send_request(row.req, 0, row.known, row.want, pred);
    end

    // Random phases, each with its own allocation window and sender idling. The
    // receiver cannot hold results off, so the phase meant for receiver stalls runs
    // without idling, and the phase with both idling uses the sender figure alone.
    // The narrow window fills up and so keeps returning disk full.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin p_floor = 1;   p_ceiling = 1024; p_idle = 0;  end
        1: begin p_floor = 0;   p_ceiling = 1024; p_idle = 47; end
        2: begin
          p_floor   = $urandom_range(2, 300);
          p_ceiling = $urandom_range(400, 1023);
          p_idle    = 0;
        end
        3: begin p_floor = 1;   p_ceiling = 1024; p_idle = 28; end
        4: begin p_floor = 900; p_ceiling = 960;  p_idle = 0;  end
        default: begin p_floor = 1; p_ceiling = 1024; p_idle = 47; end
      endcase
      write_register(fcbm_pkg::CFG_ALLOC_BASE, fcbm_pkg::CFG_W'(p_floor));
      write_register(fcbm_pkg::CFG_TOTAL_BLOCKS, fcbm_pkg::CFG_W'(p_ceiling));
      run_random_phase(PHASE_ITEMS, p_idle);
    end

    // Wait for every outstanding result, then a little longer for any stray strobe.
    start <= 1'b0;
    @(posedge clk);
    while (requests_issued != results_seen) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fcbm_pkg.sv
design/fcbm_ram.sv
design/fcbm_ctrl.sv
design/fcbm_dp.sv
design/fat_chain_block_mapper.sv
tb/sv/testbench.sv
